// ----- sv/tvz_pkg.sv -----
// Package for the tile viewport zoom and scroll block.
// Holds parameter defaults, register indexes, command codes and the controller state type.
// No dependencies.
package tvz_pkg;
    localparam int MinTileDef  = 8;
    localparam int MaxTileDef  = 64;
    localparam int TileStepDef = 4;
    localparam int ResetTile   = 16;
    localparam int CamLimit    = 32767;

    localparam logic [1:0] CMD_QUERY  = 2'd0;
    localparam logic [1:0] CMD_ZIN    = 2'd1;
    localparam logic [1:0] CMD_ZOUT   = 2'd2;
    localparam logic [1:0] CMD_SCROLL = 2'd3;

    localparam logic [1:0] REG_COLS = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;
    localparam logic [1:0] REG_VW   = 2'd2;
    localparam logic [1:0] REG_VH   = 2'd3;

    // Divider operand selection.
    localparam logic [2:0] DIV_ANCHOR_X = 3'd0;
    localparam logic [2:0] DIV_ANCHOR_Y = 3'd1;
    localparam logic [2:0] DIV_CAM_X    = 3'd2;
    localparam logic [2:0] DIV_CAM_Y    = 3'd3;
    localparam logic [2:0] DIV_VW       = 3'd4;
    localparam logic [2:0] DIV_VH       = 3'd5;
    localparam logic [2:0] DIV_PT_X     = 3'd6;
    localparam logic [2:0] DIV_PT_Y     = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_DSTART, ST_DWAIT, ST_ZOOM, ST_SCROLL,
        ST_CLAMP, ST_WIN, ST_OUT
    } t_state;

    typedef struct packed {
        logic       load;      // capture item, step tile size on zoom
        logic       div_start;
        logic [2:0] div_sel;
        logic       zoom_upd;  // compute camera from anchors
        logic       scroll_upd;
        logic       clamp;
        logic       window;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic       div_done;
        logic       size_changed;
        logic [1:0] cmd;
    } t_status;
endpackage

// ----- sv/tvz_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the datapath.
module tvz_div #(
    parameter int NW = 17,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_quo;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [DW:0]   w_trial;
    logic [DW+1:0] w_sub;

    assign w_trial = {r_rem[DW-1:0], r_quo[NW-1]};
    assign w_sub   = {1'b0, w_trial} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (w_sub[DW+1]) begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[NW-2:0], 1'b0};
                end else begin
                    r_rem <= w_sub[DW:0];
                    r_quo <= {r_quo[NW-2:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ----- sv/tvz_ctrl.sv -----
// Controller state machine for the tile viewport block.
// Depends on tvz_pkg; drives the datapath through t_cmd.
module tvz_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_out_busy,
    input  tvz_pkg::t_status i_status,
    output logic             o_stall,
    output tvz_pkg::t_cmd    o_cmd
);
    tvz_pkg::t_state r_state, n_state;
    logic [2:0] r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tvz_pkg::ST_IDLE;
            r_sel   <= '0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.div_sel = r_sel;
        o_stall = 1'b1;
        case (r_state)
            tvz_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = tvz_pkg::ST_PREP;
                end
            end
            tvz_pkg::ST_PREP: begin
                if ((i_status.cmd == tvz_pkg::CMD_ZIN || i_status.cmd == tvz_pkg::CMD_ZOUT)
                    && i_status.size_changed) begin
                    n_sel = tvz_pkg::DIV_ANCHOR_X;
                    n_state = tvz_pkg::ST_DSTART;
                end else if (i_status.cmd == tvz_pkg::CMD_SCROLL) begin
                    n_state = tvz_pkg::ST_SCROLL;
                end else begin
                    n_sel = tvz_pkg::DIV_CAM_X;
                    n_state = tvz_pkg::ST_DSTART;
                end
            end
            tvz_pkg::ST_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state = tvz_pkg::ST_DWAIT;
            end
            tvz_pkg::ST_DWAIT: begin
                if (i_status.div_done) begin
                    if (r_sel == tvz_pkg::DIV_ANCHOR_Y) begin
                        n_state = tvz_pkg::ST_ZOOM;
                    end else if (r_sel == tvz_pkg::DIV_PT_Y) begin
                        n_state = tvz_pkg::ST_WIN;
                    end else begin
                        n_sel = r_sel + 3'd1;
                        n_state = tvz_pkg::ST_DSTART;
                    end
                end
            end
            tvz_pkg::ST_ZOOM: begin
                o_cmd.zoom_upd = 1'b1;
                n_state = tvz_pkg::ST_CLAMP;
            end
            tvz_pkg::ST_SCROLL: begin
                o_cmd.scroll_upd = 1'b1;
                n_state = tvz_pkg::ST_CLAMP;
            end
            tvz_pkg::ST_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_sel = tvz_pkg::DIV_CAM_X;
                n_state = tvz_pkg::ST_DSTART;
            end
            tvz_pkg::ST_WIN: begin
                // The output registers are loaded here, so wait while the previous word
                // is still held by the receiver.
                if (!i_out_busy) begin
                    o_cmd.window = 1'b1;
                    n_state = tvz_pkg::ST_OUT;
                end
            end
            tvz_pkg::ST_OUT: begin
                if (!i_out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = tvz_pkg::ST_IDLE;
                end
            end
            default: n_state = tvz_pkg::ST_IDLE;
        endcase
    end
endmodule

// ----- sv/tvz_dp.sv -----
// Datapath of the tile viewport block: registers, camera arithmetic, shared divider.
// Depends on tvz_pkg and tvz_div.
module tvz_dp #(
    parameter int MIN_TILE  = tvz_pkg::MinTileDef,
    parameter int MAX_TILE  = tvz_pkg::MaxTileDef,
    parameter int TILE_STEP = tvz_pkg::TileStepDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tvz_pkg::t_cmd      i_cmd,
    output tvz_pkg::t_status   o_status,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [12:0]        i_cfg_data,
    input  logic [1:0]         i_cmd_code,
    input  logic [11:0]        i_pointer_x,
    input  logic [11:0]        i_pointer_y,
    input  logic signed [4:0]  i_scroll_dx,
    input  logic signed [4:0]  i_scroll_dy,
    output logic [14:0]        o_cam_x,
    output logic [14:0]        o_cam_y,
    output logic [6:0]         o_tile_px,
    output logic [7:0]         o_first_col,
    output logic [7:0]         o_first_row,
    output logic [8:0]         o_end_col,
    output logic [8:0]         o_end_row,
    output logic [11:0]        o_pointer_tile_x,
    output logic [11:0]        o_pointer_tile_y
);
    logic [8:0]  r_cols, r_rows;
    logic [12:0] r_vw, r_vh;
    logic [7:0]  r_tile, r_prev;
    logic [14:0] r_cx, r_cy;
    logic signed [18:0] r_nx, r_ny;  // unclamped camera
    logic [1:0]  r_code;
    logic [11:0] r_px, r_py;
    logic signed [4:0] r_dx, r_dy;
    logic [16:0] r_q [8];
    logic [16:0] w_num;
    logic [16:0] w_quo;
    logic        w_done;
    logic [7:0]  w_den, w_step;
    logic [7:0]  w_fc, w_fr;
    logic [8:0]  w_ec, w_er;

    // Tile size step, saturated at the limits and floored at one.
    always_comb begin
        logic [8:0] up;
        logic signed [9:0] dn;
        up = {1'b0, r_tile} + 9'(TILE_STEP);
        dn = $signed({2'b0, r_tile}) - $signed(10'(TILE_STEP));
        if (i_cmd_code == tvz_pkg::CMD_ZOUT) begin
            w_step = (dn < $signed(10'(MIN_TILE))) ? 8'(MIN_TILE) : dn[7:0];
        end else begin
            w_step = (up > 9'(MAX_TILE)) ? 8'(MAX_TILE) : up[7:0];
        end
        if (w_step == 8'd0) w_step = 8'd1;
    end

    always_comb begin
        case (i_cmd.div_sel)
            tvz_pkg::DIV_ANCHOR_X: w_num = {2'b0, r_cx} + {5'b0, r_px};
            tvz_pkg::DIV_ANCHOR_Y: w_num = {2'b0, r_cy} + {5'b0, r_py};
            tvz_pkg::DIV_CAM_X:    w_num = {2'b0, r_cx};
            tvz_pkg::DIV_CAM_Y:    w_num = {2'b0, r_cy};
            tvz_pkg::DIV_VW:       w_num = {4'b0, r_vw};
            tvz_pkg::DIV_VH:       w_num = {4'b0, r_vh};
            tvz_pkg::DIV_PT_X:     w_num = {2'b0, r_cx} + {5'b0, r_px};
            default:               w_num = {2'b0, r_cy} + {5'b0, r_py};
        endcase
        w_den = (i_cmd.div_sel == tvz_pkg::DIV_ANCHOR_X ||
                 i_cmd.div_sel == tvz_pkg::DIV_ANCHOR_Y) ? r_prev : r_tile;
    end

    tvz_div #(.NW(17), .DW(8)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(w_num), .i_den(w_den), .o_done(w_done), .o_quo(w_quo)
    );

    function automatic logic [14:0] clamp_axis(logic signed [18:0] c, logic [8:0] cells,
                                               logic [7:0] t, logic [12:0] v);
        logic signed [18:0] top;
        logic signed [18:0] r;
        top = $signed({2'b0, 17'(cells * t)}) - $signed({6'b0, v});
        if (top < 0) top = '0;
        r = c;
        if (r > top) r = top;
        if (r > 19'sd32767) r = 19'sd32767;
        if (c < 0) r = '0;
        return r[14:0];
    endfunction

    function automatic void win_axis(logic [16:0] s0, logic [16:0] vq, logic [8:0] cells,
                                     output logic [7:0] f, output logic [8:0] e);
        logic signed [18:0] s, sp, en;
        s  = $signed({2'b0, s0});
        sp = $signed({2'b0, vq}) + 19'sd1;
        en = s + sp;
        if (en > $signed({10'b0, cells})) begin
            en = $signed({10'b0, cells});
            s  = en - sp;
            if (s < 0) s = '0;
        end
        f = s[7:0];
        e = en[8:0];
    endfunction

    always_comb begin
        win_axis(r_q[2], r_q[4], r_cols, w_fc, w_ec);
        win_axis(r_q[3], r_q[5], r_rows, w_fr, w_er);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 9'd64;
            r_rows <= 9'd64;
            r_vw   <= 13'd640;
            r_vh   <= 13'd480;
            r_tile <= 8'(tvz_pkg::ResetTile);
            r_cx   <= '0;
            r_cy   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    tvz_pkg::REG_COLS: r_cols <= i_cfg_data[8:0];
                    tvz_pkg::REG_ROWS: r_rows <= i_cfg_data[8:0];
                    tvz_pkg::REG_VW:   r_vw   <= i_cfg_data;
                    tvz_pkg::REG_VH:   r_vh   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_prev <= r_tile;
                if (i_cmd_code == tvz_pkg::CMD_ZIN || i_cmd_code == tvz_pkg::CMD_ZOUT)
                    r_tile <= w_step;
            end
            if (i_cmd.zoom_upd) begin
                r_nx <= $signed({2'b0, 17'(r_q[0] * r_tile)}) - $signed({7'b0, r_px});
                r_ny <= $signed({2'b0, 17'(r_q[1] * r_tile)}) - $signed({7'b0, r_py});
            end
            if (i_cmd.scroll_upd) begin
                r_nx <= $signed({4'b0, r_cx}) + 19'(r_dx) * $signed({11'b0, r_tile});
                r_ny <= $signed({4'b0, r_cy}) + 19'(r_dy) * $signed({11'b0, r_tile});
            end
            if (i_cmd.clamp) begin
                r_cx <= clamp_axis(r_nx, r_cols, r_tile, r_vw);
                r_cy <= clamp_axis(r_ny, r_rows, r_tile, r_vh);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_code <= i_cmd_code;
            r_px <= i_pointer_x;
            r_py <= i_pointer_y;
            r_dx <= i_scroll_dx;
            r_dy <= i_scroll_dy;
        end
        if (w_done) r_q[i_cmd.div_sel] <= w_quo;
        if (i_cmd.window) begin
            o_first_col <= w_fc;
            o_end_col <= w_ec;
            o_first_row <= w_fr;
            o_end_row <= w_er;
            o_cam_x <= r_cx;
            o_cam_y <= r_cy;
            o_tile_px <= r_tile[6:0];
            o_pointer_tile_x <= r_q[6][11:0];
            o_pointer_tile_y <= r_q[7][11:0];
        end
    end

    assign o_status.div_done = w_done;
    assign o_status.size_changed = (r_tile != r_prev);
    assign o_status.cmd = r_code;
endmodule

// ----- sv/tile_viewport_zoom_scroll.sv -----
// Tile viewport zoom and scroll: top level.
// Each division runs start, 17 quotient bits and done in one shared divider.
// Queries and zooms at a size limit run six divisions; scrolls add scroll and clamp steps,
// zooms that change the size add two anchor divisions, zoom and clamp. The next word is taken
// once the result is loaded; the window step waits while the previous result is still stalled.
// Synchronous active-low reset sets 64x64 tiles, a 640x480 view, tile 16, camera 0.
module tile_viewport_zoom_scroll #(
    parameter int MIN_TILE  = tvz_pkg::MinTileDef,
    parameter int MAX_TILE  = tvz_pkg::MaxTileDef,
    parameter int TILE_STEP = tvz_pkg::TileStepDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_addr,
    input  logic [12:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_cmd,
    input  logic [11:0]       i_pointer_x,
    input  logic [11:0]       i_pointer_y,
    input  logic signed [4:0] i_scroll_dx,
    input  logic signed [4:0] i_scroll_dy,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [14:0]       o_cam_x,
    output logic [14:0]       o_cam_y,
    output logic [6:0]        o_tile_px,
    output logic [7:0]        o_first_col,
    output logic [7:0]        o_first_row,
    output logic [8:0]        o_end_col,
    output logic [8:0]        o_end_row,
    output logic [11:0]       o_pointer_tile_x,
    output logic [11:0]       o_pointer_tile_y
);
    tvz_pkg::t_cmd    w_cmd;
    tvz_pkg::t_status w_status;
    logic r_valid;

    tvz_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_out_busy(r_valid), .i_status(w_status), .o_stall(o_stall), .o_cmd(w_cmd)
    );

    tvz_dp #(.MIN_TILE(MIN_TILE), .MAX_TILE(MAX_TILE), .TILE_STEP(TILE_STEP)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .i_cmd_code(i_cmd), .i_pointer_x(i_pointer_x), .i_pointer_y(i_pointer_y),
        .i_scroll_dx(i_scroll_dx), .i_scroll_dy(i_scroll_dy),
        .o_cam_x(o_cam_x), .o_cam_y(o_cam_y), .o_tile_px(o_tile_px),
        .o_first_col(o_first_col), .o_first_row(o_first_row),
        .o_end_col(o_end_col), .o_end_row(o_end_row),
        .o_pointer_tile_x(o_pointer_tile_x), .o_pointer_tile_y(o_pointer_tile_y)
    );

    // The output word is published when the out-load step, which follows the window step, sets r_valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (w_cmd.out_load) r_valid <= 1'b1;
        else if (!i_stall) r_valid <= 1'b0;
    end
    assign o_valid = r_valid;

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second word accepted while one is in flight");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !r_valid)
        else $error("result loaded over a waiting word");
    a_tile_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_tile_px != 7'd0))
        else $error("tile size reached zero");
endmodule

// ----- test/tvz_checker.sv -----
// Checker for the tile viewport zoom and scroll block: watches both word channels,
// predicts each result from its own copy of the camera, tile size and registers.
// Depends on tvz_pkg for command codes, register indexes and tile parameters.
`timescale 1ns / 100ps

module tvz_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_addr,
    input  logic [12:0]       i_cfg_data,
    input  logic              i_valid,
    input  logic              i_stall_in,
    input  logic [1:0]        i_cmd,
    input  logic [11:0]       i_pointer_x,
    input  logic [11:0]       i_pointer_y,
    input  logic signed [4:0] i_scroll_dx,
    input  logic signed [4:0] i_scroll_dy,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [14:0]       i_cam_x,
    input  logic [14:0]       i_cam_y,
    input  logic [6:0]        i_tile_px,
    input  logic [7:0]        i_first_col,
    input  logic [7:0]        i_first_row,
    input  logic [8:0]        i_end_col,
    input  logic [8:0]        i_end_row,
    input  logic [11:0]       i_pointer_tile_x,
    input  logic [11:0]       i_pointer_tile_y,
    output int                o_errors,
    output int                o_pending,
    output int                o_results
);
    typedef struct packed {
        logic [14:0] cam_x;
        logic [14:0] cam_y;
        logic [6:0]  tile_px;
        logic [7:0]  first_col;
        logic [7:0]  first_row;
        logic [8:0]  end_col;
        logic [8:0]  end_row;
        logic [11:0] ptile_x;
        logic [11:0] ptile_y;
    } t_view;

    t_view view_q[$];
    int    map_cols, map_rows, view_w, view_h;
    int    tile_sz, cam_x, cam_y;

    function automatic int clamp_cam(int cam, int cells, int tile, int span);
        int top;
        if (cam < 0) return 0;
        top = cells * tile - span;
        if (top < 0) top = 0;
        if (cam > top) cam = top;
        if (cam > tvz_pkg::CamLimit) cam = tvz_pkg::CamLimit;
        return cam;
    endfunction

    function automatic void visible_range(input int cam, input int tile, input int span,
                                          input int cells, output int first,
                                          output int last);
        int cnt;
        first = cam / tile;
        cnt = span / tile + 1;
        last = first + cnt;
        if (last > cells) begin
            last = cells;
            first = last - cnt;
            if (first < 0) first = 0;
        end
    endfunction

    function automatic t_view predict_view(logic [1:0] cmd, int px, int py, int dx, int dy);
        t_view v;
        int nxt, ax, ay, fc, ec, fr, er;
        if (tile_sz < 1) tile_sz = 1;
        if (cmd == tvz_pkg::CMD_ZIN || cmd == tvz_pkg::CMD_ZOUT) begin
            if (cmd == tvz_pkg::CMD_ZOUT) begin
                nxt = tile_sz - tvz_pkg::TileStepDef;
                if (nxt < tvz_pkg::MinTileDef) nxt = tvz_pkg::MinTileDef;
            end else begin
                nxt = tile_sz + tvz_pkg::TileStepDef;
                if (nxt > tvz_pkg::MaxTileDef) nxt = tvz_pkg::MaxTileDef;
            end
            if (nxt < 1) nxt = 1;
            if (nxt != tile_sz) begin
                ax = (cam_x + px) / tile_sz;
                ay = (cam_y + py) / tile_sz;
                tile_sz = nxt;
                cam_x = clamp_cam(ax * nxt - px, map_cols, nxt, view_w);
                cam_y = clamp_cam(ay * nxt - py, map_rows, nxt, view_h);
            end
        end else if (cmd == tvz_pkg::CMD_SCROLL) begin
            cam_x = clamp_cam(cam_x + dx * tile_sz, map_cols, tile_sz, view_w);
            cam_y = clamp_cam(cam_y + dy * tile_sz, map_rows, tile_sz, view_h);
        end
        visible_range(cam_x, tile_sz, view_w, map_cols, fc, ec);
        visible_range(cam_y, tile_sz, view_h, map_rows, fr, er);
        v.cam_x     = cam_x[14:0];
        v.cam_y     = cam_y[14:0];
        v.tile_px   = tile_sz[6:0];
        v.first_col = fc[7:0];
        v.first_row = fr[7:0];
        v.end_col   = ec[8:0];
        v.end_row   = er[8:0];
        ax = (cam_x + px) / tile_sz;
        ay = (cam_y + py) / tile_sz;
        v.ptile_x   = ax[11:0];
        v.ptile_y   = ay[11:0];
        return v;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at result %0d: %s got %0d expected %0d", o_results, what, got,
                 want);
        o_errors++;
    endtask

    assign o_pending = view_q.size();

    always @(posedge i_clk) begin
        t_view w;
        if (!i_rst_n) begin
            map_cols = 64; map_rows = 64; view_w = 640; view_h = 480;
            tile_sz = tvz_pkg::ResetTile; cam_x = 0; cam_y = 0;
            view_q.delete();
            o_errors <= 0;
            o_results <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    tvz_pkg::REG_COLS: map_cols = i_cfg_data[8:0];
                    tvz_pkg::REG_ROWS: map_rows = i_cfg_data[8:0];
                    tvz_pkg::REG_VW:   view_w = i_cfg_data;
                    tvz_pkg::REG_VH:   view_h = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (view_q.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    w = view_q.pop_front();
                    if (i_cam_x != w.cam_x) report_mismatch("cam_x", i_cam_x, w.cam_x);
                    if (i_cam_y != w.cam_y) report_mismatch("cam_y", i_cam_y, w.cam_y);
                    if (i_tile_px != w.tile_px)
                        report_mismatch("tile_px", i_tile_px, w.tile_px);
                    if (i_first_col != w.first_col)
                        report_mismatch("first_col", i_first_col, w.first_col);
                    if (i_first_row != w.first_row)
                        report_mismatch("first_row", i_first_row, w.first_row);
                    if (i_end_col != w.end_col)
                        report_mismatch("end_col", i_end_col, w.end_col);
                    if (i_end_row != w.end_row)
                        report_mismatch("end_row", i_end_row, w.end_row);
                    if (i_pointer_tile_x != w.ptile_x)
                        report_mismatch("pointer_tile_x", i_pointer_tile_x, w.ptile_x);
                    if (i_pointer_tile_y != w.ptile_y)
                        report_mismatch("pointer_tile_y", i_pointer_tile_y, w.ptile_y);
                end
                o_results <= o_results + 1;
            end
            if (i_valid && !i_stall_in)
                view_q.push_back(predict_view(i_cmd, i_pointer_x, i_pointer_y,
                                              i_scroll_dx, i_scroll_dy));
        end
    end
endmodule

// ----- test/tb_tile_viewport_zoom_scroll.sv -----
// Testbench top for the tile viewport zoom and scroll block: drives commands and
// register writes under varied idling, and gives the verdict from tvz_checker.
// Depends on tvz_pkg, tile_viewport_zoom_scroll and tvz_checker.
`timescale 1ns / 100ps

module tb_tile_viewport_zoom_scroll;
    localparam int CycleLimit = 3_000_000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [1:0]        cfg_addr = tvz_pkg::REG_COLS;
    logic [12:0]       cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        cmd = tvz_pkg::CMD_QUERY;
    logic [11:0]       ptr_x = '0;
    logic [11:0]       ptr_y = '0;
    logic signed [4:0] dx = '0;
    logic signed [4:0] dy = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [14:0]       cam_x, cam_y;
    logic [6:0]        tile_px;
    logic [7:0]        first_col, first_row;
    logic [8:0]        end_col, end_row;
    logic [11:0]       ptile_x, ptile_y;
    int                errors, pending, results;
    int                cycles = 0;
    int                send_idle = 0;
    int                recv_stall = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    tile_viewport_zoom_scroll dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_cmd(cmd), .i_pointer_x(ptr_x), .i_pointer_y(ptr_y),
        .i_scroll_dx(dx), .i_scroll_dy(dy),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_cam_x(cam_x), .o_cam_y(cam_y), .o_tile_px(tile_px),
        .o_first_col(first_col), .o_first_row(first_row),
        .o_end_col(end_col), .o_end_row(end_row),
        .o_pointer_tile_x(ptile_x), .o_pointer_tile_y(ptile_y)
    );

    tvz_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_stall_in(in_stall),
        .i_cmd(cmd), .i_pointer_x(ptr_x), .i_pointer_y(ptr_y),
        .i_scroll_dx(dx), .i_scroll_dy(dy),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_cam_x(cam_x), .i_cam_y(cam_y), .i_tile_px(tile_px),
        .i_first_col(first_col), .i_first_row(first_row),
        .i_end_col(end_col), .i_end_row(end_row),
        .i_pointer_tile_x(ptile_x), .i_pointer_tile_y(ptile_y),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout with %0d words outstanding", pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver stall, percentage chosen per phase.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall);

    // The write enable stays high between writes; set_map lowers it after the last one.
    task automatic write_reg(logic [1:0] idx, int val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val[12:0];
        @(posedge clk);
    endtask

    // Lowers valid and lets the checker see the last accepted word before waiting for the drain.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic set_map(int cols, int rows, int vw, int vh);
        wait_drained();
        write_reg(tvz_pkg::REG_COLS, cols);
        write_reg(tvz_pkg::REG_ROWS, rows);
        write_reg(tvz_pkg::REG_VW, vw);
        write_reg(tvz_pkg::REG_VH, vh);
        cfg_we <= 1'b0;
    endtask

    // Offers one word and holds it until it is taken. Valid is lowered by the next
    // idle cycle or by a drain, so back-to-back words need no gap.
    task automatic send_word(logic [1:0] c, int px, int py, int sx, int sy);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        ptr_x    <= px[11:0];
        ptr_y    <= py[11:0];
        dx       <= sx[4:0];
        dy       <= sy[4:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Pointer mostly inside the view, sometimes anywhere in the field.
    function automatic int pick_ptr(int span);
        if ($urandom_range(9) == 0 || span < 1) return $urandom_range(4095);
        return $urandom_range(span > 4096 ? 4095 : span - 1);
    endfunction

    task automatic random_run(int n, int vw, int vh);
        int k;
        logic [1:0] c;
        for (k = 0; k < n; k++) begin
            c = $urandom_range(3);
            send_word(c, pick_ptr(vw), pick_ptr(vh),
                      $signed($urandom_range(31)) - 16, $signed($urandom_range(31)) - 16);
        end
    endtask

    initial begin
        int ph;
        int cols, rows, vw, vh;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of pointer and scroll, tile size walked to both limits.
        send_word(tvz_pkg::CMD_QUERY, 0, 0, 0, 0);
        send_word(tvz_pkg::CMD_QUERY, 4095, 4095, 0, 0);
        send_word(tvz_pkg::CMD_SCROLL, 0, 0, 15, 15);
        send_word(tvz_pkg::CMD_SCROLL, 0, 0, -16, -16);
        send_word(tvz_pkg::CMD_SCROLL, 0, 0, -16, 15);
        repeat (3) send_word(tvz_pkg::CMD_ZOUT, 100, 50, 0, 0);
        repeat (13) send_word(tvz_pkg::CMD_ZIN, 639, 479, 0, 0);
        send_word(tvz_pkg::CMD_ZIN, 4095, 0, 0, 0);
        send_word(tvz_pkg::CMD_SCROLL, 2730, 1365, 10, -6);

        // Tiny map and view, then a 256x256 map with a 4096x4096 view, then a zero-size map.
        set_map(1, 1, 1, 1);
        send_word(tvz_pkg::CMD_SCROLL, 0, 0, 15, 15);
        send_word(tvz_pkg::CMD_ZOUT, 0, 0, 0, 0);
        send_word(tvz_pkg::CMD_QUERY, 4095, 4095, 0, 0);
        set_map(256, 256, 4096, 4096);
        send_word(tvz_pkg::CMD_SCROLL, 0, 0, 15, 15);
        send_word(tvz_pkg::CMD_ZIN, 4095, 4095, 0, 0);
        set_map(0, 0, 0, 0);
        send_word(tvz_pkg::CMD_SCROLL, 0, 0, 1, 1);
        send_word(tvz_pkg::CMD_QUERY, 5, 5, 0, 0);

        for (ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 66; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 66; end
                default: begin send_idle = 29; recv_stall = 29; end
            endcase
            case (ph % 3)
                0: begin
                    cols = $urandom_range(256, 1); rows = $urandom_range(256, 1);
                    vw = $urandom_range(4096, 1);  vh = $urandom_range(4096, 1);
                end
                1: begin
                    cols = $urandom_range(64, 8);  rows = $urandom_range(64, 8);
                    vw = $urandom_range(800, 64);  vh = $urandom_range(600, 64);
                end
                default: begin
                    cols = $urandom_range(8192 / 32 - 1, 1) | 9'h100 * (ph & 1);
                    rows = $urandom_range(256, 1);
                    vw = 8191 - $urandom_range(4095); vh = $urandom_range(31, 1);
                end
            endcase
            set_map(cols, rows, vw, vh);
            random_run(150, vw, vh);
            if (ph == 5) begin
                // Sender holds off until everything outstanding has come back.
                wait_drained();
                random_run(5, vw, vh);
            end
        end

        wait_drained();
        $display("covered %0d words over twelve register settings and four idle mixes",
                 results);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
